### rtl/dteq_pkg.sv
// ----------------------------------------------------------------------------
// dteq_pkg
// Shared types and constants for the delta-list event queue.
// ----------------------------------------------------------------------------
package dteq_pkg;

    localparam int CAPACITY_DEF = 32;

    localparam int TYPE_W  = 16;
    localparam int PLO_W   = 64;
    localparam int PHI_W   = 48;
    localparam int DELTA_W = 31;
    localparam int OUT_D_W = 32;

    localparam logic [DELTA_W-1:0] APPEND_DELAY = 31'h7FFF_FFFF;
    localparam logic [TYPE_W-1:0]  EMPTY_TYPE   = 16'hFFFF;

    typedef enum logic [1:0] {
        OP_POST  = 2'd0,
        OP_POP   = 2'd1,
        OP_FLUSH = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD,
        ST_PR,
        ST_FIN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [TYPE_W-1:0]  ev_type;
        logic [PLO_W-1:0]   pl_lo;
        logic [PHI_W-1:0]   pl_hi;
        logic [DELTA_W-1:0] delta;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

### rtl/dteq_ram.sv
// ----------------------------------------------------------------------------
// dteq_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module dteq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

### rtl/delta_time_event_queue.sv
// ----------------------------------------------------------------------------
// delta_time_event_queue
// Time-ordered event queue kept as a delta list in one RAM, ordered by
// queue position. Post, pop and flush each walk the list under a sequencer.
// ----------------------------------------------------------------------------
//  channel   | handshake             | fields
//  ----------+-----------------------+------------------------------------------
//  request   | start / busy          | i_operation, i_event_type, i_payload_*,
//            |                       | i_delay, i_allow_last_slot
//  result    | o_result_valid strobe | o_event_type_out, o_payload_*_out,
//            |                       | o_delay_out, o_accepted
//
//  A request walks the N queued events through a RAM read state (ST_RD) and
//  a process/write state (ST_PR) per entry on the single RAM port pair, then
//  ST_FIN and ST_DONE; an empty post or flush skips the walk, and a dropped
//  post, an empty pop or an unknown operation goes straight to ST_DONE.
//  Reset empties the queue at once; RAM contents are never read unwritten.
//  busy stays high from the accepted request through the result strobe.
//  The result is shown for one cycle and cannot be held off.
// ----------------------------------------------------------------------------
module delta_time_event_queue
    import dteq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [1:0]                i_operation,
    input  logic signed [TYPE_W-1:0]  i_event_type,
    input  logic [PLO_W-1:0]          i_payload_low,
    input  logic [PHI_W-1:0]          i_payload_high,
    input  logic [DELTA_W-1:0]        i_delay,
    input  logic                      i_allow_last_slot,
    output logic                      o_result_valid,
    output logic signed [TYPE_W-1:0]  o_event_type_out,
    output logic [PLO_W-1:0]          o_payload_low_out,
    output logic [PHI_W-1:0]          o_payload_high_out,
    output logic [OUT_D_W-1:0]        o_delay_out,
    output logic                      o_accepted
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    t_state             r_state, n_state;
    t_op                r_op, n_op;
    t_entry             r_new, n_new;
    t_entry             r_hold, n_hold;
    logic [DELTA_W-1:0] r_rem, n_rem;
    logic [CW-1:0]      r_count, n_count;
    logic [CW-1:0]      r_pos, n_pos;
    logic [CW-1:0]      r_nk, n_nk;
    logic [DELTA_W-1:0] r_carry, n_carry;
    logic [OUT_D_W-1:0] r_cum, n_cum;
    logic               r_found, n_found;
    logic               r_ins, n_ins;
    logic [TYPE_W-1:0]  r_type_o, n_type_o;
    logic [PLO_W-1:0]   r_plo_o, n_plo_o;
    logic [PHI_W-1:0]   r_phi_o, n_phi_o;
    logic [OUT_D_W-1:0] r_dly_o, n_dly_o;
    logic               r_acc_o, n_acc_o;

    logic               w_we;
    logic [IW-1:0]      w_waddr;
    t_entry             w_wdata;
    t_entry             w_rdata;
    logic [ENTRY_W-1:0] w_rraw;
    logic [DELTA_W-1:0] w_fold;
    logic [CW-1:0]      w_pos_nx;

    assign w_rdata = t_entry'(w_rraw);

    dteq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (ENTRY_W'(w_wdata)),
        .i_raddr (r_pos[IW-1:0]),
        .o_rdata (w_rraw)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_new    <= n_new;
        r_hold   <= n_hold;
        r_rem    <= n_rem;
        r_pos    <= n_pos;
        r_nk     <= n_nk;
        r_carry  <= n_carry;
        r_cum    <= n_cum;
        r_found  <= n_found;
        r_ins    <= n_ins;
        r_type_o <= n_type_o;
        r_plo_o  <= n_plo_o;
        r_phi_o  <= n_phi_o;
        r_dly_o  <= n_dly_o;
        r_acc_o  <= n_acc_o;
    end

    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_new    = r_new;
        n_hold   = r_hold;
        n_rem    = r_rem;
        n_count  = r_count;
        n_pos    = r_pos;
        n_nk     = r_nk;
        n_carry  = r_carry;
        n_cum    = r_cum;
        n_found  = r_found;
        n_ins    = r_ins;
        n_type_o = r_type_o;
        n_plo_o  = r_plo_o;
        n_phi_o  = r_phi_o;
        n_dly_o  = r_dly_o;
        n_acc_o  = r_acc_o;
        w_we     = 1'b0;
        w_waddr  = r_pos[IW-1:0];
        w_wdata  = r_hold;
        w_fold   = w_rdata.delta + r_carry;
        w_pos_nx = r_pos + 1'b1;

        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_op          = t_op'(i_operation);
                    n_new.ev_type = i_event_type;
                    n_new.pl_lo   = i_payload_low;
                    n_new.pl_hi   = i_payload_high;
                    // hold the requested delay to detect an append at the end
                    n_new.delta   = i_delay;
                    n_rem         = i_delay;
                    n_pos         = '0;
                    n_nk          = '0;
                    n_carry       = '0;
                    n_cum         = '0;
                    n_found       = 1'b0;
                    n_ins         = 1'b0;
                    n_type_o      = '0;
                    n_plo_o       = '0;
                    n_phi_o       = '0;
                    n_dly_o       = '0;
                    n_acc_o       = 1'b0;
                    unique case (t_op'(i_operation))
                        OP_POST: begin
                            // drop when full, or on the last slot unless allowed
                            if (r_count == CW'(CAPACITY) ||
                                (r_count == CW'(CAPACITY - 1) && !i_allow_last_slot)) begin
                                n_state = ST_DONE;
                            end else if (r_count == '0) begin
                                n_state = ST_FIN;
                            end else begin
                                n_state = ST_RD;
                            end
                        end
                        OP_POP: begin
                            if (r_count == '0) begin
                                n_type_o = EMPTY_TYPE;
                                n_state  = ST_DONE;
                            end else begin
                                n_state = ST_RD;
                            end
                        end
                        OP_FLUSH: begin
                            n_state = (r_count == '0) ? ST_FIN : ST_RD;
                        end
                        default: begin
                            n_state = ST_DONE;
                        end
                    endcase
                end
            end
            ST_RD: begin
                n_state = ST_PR;
            end
            ST_PR: begin
                case (r_op)
                    OP_POST: begin
                        if (r_ins) begin
                            // shift the tail down by one
                            w_we    = 1'b1;
                            w_wdata = r_hold;
                            n_hold  = w_rdata;
                        end else if (r_rem < w_rdata.delta) begin
                            w_we          = 1'b1;
                            w_wdata       = r_new;
                            w_wdata.delta = r_rem;
                            n_hold        = w_rdata;
                            n_hold.delta  = w_rdata.delta - r_rem;
                            n_ins         = 1'b1;
                        end else begin
                            n_rem = r_rem - w_rdata.delta;
                        end
                    end
                    OP_POP: begin
                        if (r_pos == '0) begin
                            n_type_o = w_rdata.ev_type;
                            n_plo_o  = w_rdata.pl_lo;
                            n_phi_o  = w_rdata.pl_hi;
                            n_dly_o  = {1'b0, w_rdata.delta};
                        end else begin
                            w_we    = 1'b1;
                            w_waddr = IW'(r_pos - 1'b1);
                            w_wdata = w_rdata;
                        end
                    end
                    default: begin
                        n_cum = r_cum + {1'b0, w_rdata.delta};
                        if (w_rdata.ev_type == r_new.ev_type) begin
                            if (!r_found) begin
                                n_found = 1'b1;
                                n_dly_o = n_cum;
                            end
                            n_carry = w_fold;
                        end else begin
                            // keep: fold carried time in, compact down
                            w_we          = 1'b1;
                            w_waddr       = r_nk[IW-1:0];
                            w_wdata       = w_rdata;
                            w_wdata.delta = w_fold;
                            n_carry       = '0;
                            n_nk          = r_nk + 1'b1;
                        end
                    end
                endcase
                n_pos   = w_pos_nx;
                n_state = (w_pos_nx == r_count) ? ST_FIN : ST_RD;
            end
            ST_FIN: begin
                case (r_op)
                    OP_POST: begin
                        w_we    = 1'b1;
                        w_waddr = r_count[IW-1:0];
                        if (r_ins) begin
                            w_wdata = r_hold;
                        end else begin
                            w_wdata       = r_new;
                            w_wdata.delta = (r_new.delta == APPEND_DELAY) ? '0 : r_rem;
                        end
                        n_count = r_count + 1'b1;
                        n_acc_o = 1'b1;
                    end
                    OP_POP: begin
                        n_count = r_count - 1'b1;
                    end
                    default: begin
                        n_count = r_nk;
                    end
                endcase
                n_state = ST_DONE;
            end
            ST_DONE: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign busy               = (r_state != ST_IDLE);
    assign o_result_valid     = (r_state == ST_DONE);
    assign o_event_type_out   = r_type_o;
    assign o_payload_low_out  = r_plo_o;
    assign o_payload_high_out = r_phi_o;
    assign o_delay_out        = r_dly_o;
    assign o_accepted         = r_acc_o;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("queue count exceeds capacity");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !busy)
        else $error("block stays busy after result");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted without going busy");

    a_post_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_accepted) |-> (r_count == CW'($past(r_count) + 1'b1)))
        else $error("accepted post did not grow the queue");

endmodule

### bench/delta_time_event_queue_tb.sv
// ----------------------------------------------------------------------------
// delta_time_event_queue_tb
// Drives post, pop and flush requests into the delta-list event queue with
// random start gaps, predicts each result with a queue model kept in
// position order, and compares every result strobe field by field.
// ----------------------------------------------------------------------------
module delta_time_event_queue_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import dteq_pkg::*;

    localparam int CAP       = CAPACITY_DEF;
    localparam int IDLE_LIM  = 20000;
    localparam int N_RANDOM  = 750;

    typedef struct packed {
        logic [1:0]         op;
        logic [TYPE_W-1:0]  ev_type;
        logic [PLO_W-1:0]   pl_lo;
        logic [PHI_W-1:0]   pl_hi;
        logic [DELTA_W-1:0] delay;
        logic               allow_last;
    } t_request;

    typedef struct packed {
        logic [TYPE_W-1:0]  ev_type;
        logic [PLO_W-1:0]   pl_lo;
        logic [PHI_W-1:0]   pl_hi;
        logic [OUT_D_W-1:0] delay;
        logic               accepted;
    } t_result;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         i_operation;
    logic [TYPE_W-1:0]  i_event_type;
    logic [PLO_W-1:0]   i_payload_low;
    logic [PHI_W-1:0]   i_payload_high;
    logic [DELTA_W-1:0] i_delay;
    logic               i_allow_last_slot;
    logic               o_result_valid;
    logic [TYPE_W-1:0]  o_event_type_out;
    logic [PLO_W-1:0]   o_payload_low_out;
    logic [PHI_W-1:0]   o_payload_high_out;
    logic [OUT_D_W-1:0] o_delay_out;
    logic               o_accepted;

    t_request pending_reqs[$];
    t_result  expected_results[$];
    t_entry   timer_list[$];      // head first, delta relative to predecessor
    int       mismatches;
    int       stall_cycles;
    bit       stim_done;
    bit       gap_enable;

    delta_time_event_queue u_dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic t_result predict_request(t_request r);
        t_result res;
        t_entry  e;
        logic [31:0] rem, cum, first;
        logic [DELTA_W-1:0] carry;
        t_entry  kept[$];
        int      pos, free_slots;
        bit      found;
        res = '0;
        case (t_op'(r.op))
            OP_POST: begin
                free_slots = CAP - timer_list.size();
                if (free_slots == 0 || (free_slots == 1 && !r.allow_last)) return res;
                res.accepted = 1'b1;
                e.ev_type = r.ev_type;
                e.pl_lo = r.pl_lo;
                e.pl_hi = r.pl_hi;
                rem = {1'b0, r.delay};
                pos = timer_list.size();
                for (int p = 0; p < timer_list.size(); p++) begin
                    if (rem < timer_list[p].delta) begin
                        pos = p;
                        break;
                    end
                    rem -= timer_list[p].delta;
                end
                if (pos < timer_list.size()) begin
                    e.delta = rem[DELTA_W-1:0];
                    timer_list[pos].delta = timer_list[pos].delta - rem[DELTA_W-1:0];
                end else begin
                    e.delta = (r.delay == APPEND_DELAY) ? '0 : rem[DELTA_W-1:0];
                end
                timer_list.insert(pos, e);
            end
            OP_POP: begin
                if (timer_list.size() == 0) begin
                    res.ev_type = EMPTY_TYPE;
                    return res;
                end
                e = timer_list.pop_front();
                res.ev_type = e.ev_type;
                res.pl_lo = e.pl_lo;
                res.pl_hi = e.pl_hi;
                res.delay = {1'b0, e.delta};
            end
            OP_FLUSH: begin
                carry = '0;
                cum = '0;
                first = '0;
                found = 1'b0;
                foreach (timer_list[p]) begin
                    e = timer_list[p];
                    cum += {1'b0, e.delta};
                    e.delta = e.delta + carry;
                    if (e.ev_type == r.ev_type) begin
                        if (!found) first = cum;
                        found = 1'b1;
                        carry = e.delta;
                    end else begin
                        carry = '0;
                        kept.push_back(e);
                    end
                end
                timer_list = kept;
                res.delay = first;
            end
            default: ;
        endcase
        return res;
    endfunction

    // driver: hold start until busy is low at an edge
    always @(posedge i_clk) begin
        t_request r;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || !busy) begin
            if (start) begin
                r = pending_reqs.pop_front();
                expected_results.push_back(predict_request(r));
            end
            if (pending_reqs.size() > 0 && (!gap_enable || $urandom_range(99) >= 33)) begin
                r = pending_reqs[0];
                start <= 1'b1;
                i_operation <= r.op;
                i_event_type <= r.ev_type;
                i_payload_low <= r.pl_lo;
                i_payload_high <= r.pl_hi;
                i_delay <= r.delay;
                i_allow_last_slot <= r.allow_last;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_result got, exp_r;
        if (i_rst_n && o_result_valid) begin
            got = '{o_event_type_out, o_payload_low_out, o_payload_high_out,
                    o_delay_out, o_accepted};
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
            end else begin
                exp_r = expected_results.pop_front();
                if (got !== exp_r) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: type %h/%h lo %h/%h hi %h/%h dly %h/%h acc %b/%b",
                                 exp_r.ev_type, got.ev_type, exp_r.pl_lo, got.pl_lo,
                                 exp_r.pl_hi, got.pl_hi, exp_r.delay, got.delay,
                                 exp_r.accepted, got.accepted);
                end
            end
        end
    end

    // watchdog: count cycles without a handshake
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_result_valid) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= IDLE_LIM && !stim_done) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic t_request make_req(logic [1:0] op, logic [TYPE_W-1:0] ty,
                                          logic [DELTA_W-1:0] dly, logic allow);
        t_request r;
        r.op = op;
        r.ev_type = ty;
        r.pl_lo = {$urandom, $urandom};
        r.pl_hi = PHI_W'({$urandom, $urandom});
        r.delay = dly;
        r.allow_last = allow;
        return r;
    endfunction

    function automatic logic [DELTA_W-1:0] rand_delay();
        case ($urandom_range(5))
            0: return APPEND_DELAY;
            1: return DELTA_W'($urandom_range(3));
            2: return DELTA_W'($urandom);
            default: return DELTA_W'($urandom_range(200));
        endcase
    endfunction

    initial begin
        int sel, wait_cnt;
        logic [TYPE_W-1:0] ty;
        t_request r;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_operation = '0;
        i_event_type = '0;
        i_payload_low = '0;
        i_payload_high = '0;
        i_delay = '0;
        i_allow_last_slot = 1'b0;
        mismatches = 0;
        stall_cycles = 0;
        stim_done = 1'b0;
        gap_enable = 1'b1;

        // directed: empty pop and flush, an unknown op, extremes, twelve small posts, flushes by type
        pending_reqs.push_back(make_req(OP_POP, 16'h0, '0, 1'b0));
        pending_reqs.push_back(make_req(OP_FLUSH, 16'h7, '0, 1'b0));
        pending_reqs.push_back(make_req(OP_NONE, 16'hFFFF, '1, 1'b1));
        r = make_req(OP_POST, 16'h8000, '0, 1'b0);
        r.pl_lo = '1;
        r.pl_hi = '1;
        pending_reqs.push_back(r);
        pending_reqs.push_back(make_req(OP_POST, 16'h7FFF, APPEND_DELAY, 1'b0));
        pending_reqs.push_back(make_req(OP_POST, 16'h0010, 31'h7FFF_FFFE, 1'b1));
        pending_reqs.push_back(make_req(OP_FLUSH, 16'h7FFF, '0, 1'b0));
        pending_reqs.push_back(make_req(OP_POP, 16'h0, '0, 1'b0));
        for (int i = 0; i < 12; i++)
            pending_reqs.push_back(make_req(OP_POST, 16'(i % 3), 31'($urandom_range(50)),
                                            1'b0));
        pending_reqs.push_back(make_req(OP_FLUSH, 16'h1, '0, 1'b0));
        pending_reqs.push_back(make_req(OP_FLUSH, 16'h0, '0, 1'b0));
        pending_reqs.push_back(make_req(OP_FLUSH, 16'h2, '0, 1'b0));
        pending_reqs.push_back(make_req(OP_FLUSH, 16'h8000, '0, 1'b0));

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // random: phases that fill and drain
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i >= 300 && i < 400) gap_enable = 1'b0;
            else gap_enable = 1'b1;
            sel = $urandom_range(99);
            ty = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(3));
            if ((i / 120) % 2 == 0) begin
                if (sel < 70) r = make_req(OP_POST, ty, rand_delay(), 1'($urandom));
                else if (sel < 85) r = make_req(OP_POP, ty, rand_delay(), 1'($urandom));
                else if (sel < 97) r = make_req(OP_FLUSH, ty, rand_delay(), 1'($urandom));
                else r = make_req(OP_NONE, ty, rand_delay(), 1'($urandom));
            end else begin
                if (sel < 35) r = make_req(OP_POST, ty, rand_delay(), 1'($urandom));
                else if (sel < 75) r = make_req(OP_POP, ty, rand_delay(), 1'($urandom));
                else if (sel < 97) r = make_req(OP_FLUSH, ty, rand_delay(), 1'($urandom));
                else r = make_req(OP_NONE, ty, rand_delay(), 1'($urandom));
            end
            pending_reqs.push_back(r);
            while (pending_reqs.size() > 8) @(posedge i_clk);
        end

        while (pending_reqs.size() > 0 || start) @(posedge i_clk);
        wait_cnt = 0;
        while (expected_results.size() > 0 && wait_cnt < IDLE_LIM) begin
            @(posedge i_clk);
            wait_cnt++;
        end
        stim_done = 1'b1;
        repeat (2 * CAP + 10) @(posedge i_clk);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/dteq_pkg.sv
rtl/dteq_ram.sv
rtl/delta_time_event_queue.sv
bench/delta_time_event_queue_tb.sv
